// ----- src/cob_pkg.sv -----
// Shared types and opcode codes for the opcode 0x00-0x1F execute block.
// No dependencies; used by cob_exec and the top level.
`timescale 1ns / 1ps
package cob_pkg;

	localparam int MEM_ADDR_BITS_DEF = 16;

	localparam logic [4:0] OP_NOP        = 5'h00;
	localparam logic [4:0] OP_LD_BC_D16  = 5'h01;
	localparam logic [4:0] OP_LD_MBC_A   = 5'h02;
	localparam logic [4:0] OP_INC_BC     = 5'h03;
	localparam logic [4:0] OP_INC_B      = 5'h04;
	localparam logic [4:0] OP_DEC_B      = 5'h05;
	localparam logic [4:0] OP_LD_B_D8    = 5'h06;
	localparam logic [4:0] OP_RLCA       = 5'h07;
	localparam logic [4:0] OP_LD_MA16_SP = 5'h08;
	localparam logic [4:0] OP_ADD_HL_BC  = 5'h09;
	localparam logic [4:0] OP_LD_A_MBC   = 5'h0A;
	localparam logic [4:0] OP_DEC_BC     = 5'h0B;
	localparam logic [4:0] OP_INC_C      = 5'h0C;
	localparam logic [4:0] OP_DEC_C      = 5'h0D;
	localparam logic [4:0] OP_LD_C_D8    = 5'h0E;
	localparam logic [4:0] OP_RRCA       = 5'h0F;
	localparam logic [4:0] OP_STOP       = 5'h10;
	localparam logic [4:0] OP_LD_DE_D16  = 5'h11;
	localparam logic [4:0] OP_LD_MDE_A   = 5'h12;
	localparam logic [4:0] OP_INC_DE     = 5'h13;
	localparam logic [4:0] OP_INC_D      = 5'h14;
	localparam logic [4:0] OP_DEC_D      = 5'h15;
	localparam logic [4:0] OP_LD_D_D8    = 5'h16;
	localparam logic [4:0] OP_RLA        = 5'h17;
	localparam logic [4:0] OP_JR         = 5'h18;
	localparam logic [4:0] OP_ADD_HL_DE  = 5'h19;
	localparam logic [4:0] OP_LD_A_MDE   = 5'h1A;
	localparam logic [4:0] OP_DEC_DE     = 5'h1B;
	localparam logic [4:0] OP_INC_E      = 5'h1C;
	localparam logic [4:0] OP_DEC_E      = 5'h1D;
	localparam logic [4:0] OP_LD_E_D8    = 5'h1E;
	localparam logic [4:0] OP_RRA        = 5'h1F;

	// flag nibble: Z N H C
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  a;
		logic [3:0]  f;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
	} cob_regs_t;

	typedef struct packed {
		logic        mem_we;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic        mem_re;
		logic [15:0] raddr;
		logic        sp_hi;
		logic [15:0] hi_addr;
		logic [2:0]  cyc;
	} cob_ctl_t;

endpackage

// ----- src/cob_if.sv -----
// Handshake channel interfaces for commands and results.
// No dependencies; the payload is plain fields, none of the cob_pkg types.
`timescale 1ns / 1ps
interface cob_cmd_if;
	logic        valid;
	logic        ready;
	logic [4:0]  op;
	logic [15:0] imm;
	modport source (output valid, op, imm, input ready);
	modport sink (input valid, op, imm, output ready);
endinterface

interface cob_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] pc_out;
	logic [7:0]  acc;
	logic [7:0]  flags;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_d;
	logic [7:0]  reg_e;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [2:0]  cycles_used;
	modport source (output valid, pc_out, acc, flags, reg_b, reg_c, reg_d, reg_e,
		reg_h, reg_l, cycles_used, input ready);
	modport sink (input valid, pc_out, acc, flags, reg_b, reg_c, reg_d, reg_e,
		reg_h, reg_l, cycles_used, output ready);
endinterface

// ----- src/cpu_opcode_block_0x00_0x1f_unit.sv -----
// Execute unit for opcodes 0x00-0x1F with its register file and byte memory.
// After reset a clearing pass zeroes the byte memory, one byte per cycle, over all
// 2**MEM_ADDR_BITS bytes (65536 at the default); no command beat is taken
// meanwhile, stack pointer writes are. Afterwards a command beat is taken every
// cycle while the output register is empty or being taken, except that the
// loads of A through BC or DE and the SP store (0x08) hold the command side in
// the cycle after they are taken: the load waits for the registered read of the
// memory, the SP store needs a second pass through the single write port. A
// result beat sits in an output register and does not stop the next command
// while the sink takes it. Depends on cob_pkg, cob_if and cob_exec.
`timescale 1ns / 1ps
module cpu_opcode_block_0x00_0x1f_unit import cob_pkg::*; #(
	parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	cob_cmd_if.sink     cmd,
	cob_res_if.source   res
);

	localparam int AW = MEM_ADDR_BITS;

	typedef struct packed {
		cob_regs_t  r;
		logic [2:0] cyc;
	} cob_out_t;

	// byte memory, no reset: cleared by the sweep below
	logic [7:0] mem [0:(2**AW)-1];

	logic [15:0] sp_q;
	cob_regs_t   st_q, nxt;
	cob_ctl_t    ctl;
	cob_out_t    out_q;
	logic        ov_q, ld_q, wr2_q, clr_q;
	logic [2:0]  ld_cyc_q;
	logic [AW-1:0] clr_addr_q;
	logic [15:0] hi_addr_q;
	logic [7:0]  rdata_q;
	logic        acc_in, we;
	logic [AW-1:0] waddr;
	logic [7:0]  wdata;

	cob_exec u_exec (
		.op (cmd.op), .imm (cmd.imm), .sp (sp_q), .cur (st_q), .nxt (nxt), .ctl (ctl)
	);

	// stalls while clearing, on a pending load or second SP byte, or a full output
	assign cmd.ready = !clr_q && !ld_q && !wr2_q && (!ov_q || res.ready);
	assign acc_in = cmd.valid && cmd.ready;

	always_comb begin
		if (clr_q) begin
			we = 1'b1; waddr = clr_addr_q; wdata = 8'h00;
		end else if (wr2_q) begin
			we = 1'b1; waddr = hi_addr_q[AW-1:0]; wdata = sp_q[15:8];
		end else begin
			we = acc_in && ctl.mem_we; waddr = ctl.waddr[AW-1:0]; wdata = ctl.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// reads never meet a write to the same byte in the same cycle
	always_ff @(posedge clk) begin
		if (acc_in && ctl.mem_re) rdata_q <= mem[ctl.raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc_in && ctl.sp_hi) hi_addr_q <= ctl.hi_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= 16'hFFFE;
		end else if (cfg_we) begin
			sp_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			ov_q     <= 1'b0;
			ld_q     <= 1'b0;
			wr2_q    <= 1'b0;
			ld_cyc_q <= '0;
			out_q    <= '0;
		end else begin
			if (ov_q && res.ready) ov_q <= 1'b0;
			wr2_q <= acc_in && ctl.sp_hi;
			if (acc_in) begin
				st_q <= nxt;
				ld_q <= ctl.mem_re;
				ld_cyc_q <= ctl.cyc;
				if (!ctl.mem_re) begin
					out_q <= '{r: nxt, cyc: ctl.cyc};
					ov_q  <= 1'b1;
				end
			end else if (ld_q) begin
				// load completes: output register is known empty here
				st_q.a <= rdata_q;
				out_q  <= '{r: '{pc: st_q.pc, a: rdata_q, f: st_q.f, b: st_q.b,
					c: st_q.c, d: st_q.d, e: st_q.e, h: st_q.h, l: st_q.l}, cyc: ld_cyc_q};
				ov_q   <= 1'b1;
				ld_q   <= 1'b0;
			end
		end
	end

	assign res.valid       = ov_q;
	assign res.pc_out      = out_q.r.pc;
	assign res.acc         = out_q.r.a;
	assign res.flags       = {out_q.r.f, 4'h0};
	assign res.reg_b       = out_q.r.b;
	assign res.reg_c       = out_q.r.c;
	assign res.reg_d       = out_q.r.d;
	assign res.reg_e       = out_q.r.e;
	assign res.reg_h       = out_q.r.h;
	assign res.reg_l       = out_q.r.l;
	assign res.cycles_used = out_q.cyc;

	a_ld_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld_q |-> !ov_q) else $error("load result with output register busy");
	a_ld_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && ctl.mem_re) |=> (ld_q && !cmd.ready))
		else $error("memory load not held for read data");
	a_wr2_once: assert property (@(posedge clk) disable iff (!arst_n)
		wr2_q |=> !wr2_q) else $error("second SP byte written twice");
	a_no_cmd_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !cmd.ready) else $error("command taken during clearing pass");

endmodule

// ----- src/cob_exec.sv -----
// Combinational decode and execute of one opcode: next register state and
// memory requests. Depends on cob_pkg.
`timescale 1ns / 1ps
module cob_exec import cob_pkg::*; (
	input  logic [4:0]  op,
	input  logic [15:0] imm,
	input  logic [15:0] sp,
	input  cob_regs_t   cur,
	output cob_regs_t   nxt,
	output cob_ctl_t    ctl
);

	function automatic logic [11:0] inc8(input logic [7:0] o, input logic cy);
		logic [7:0] n;
		n = o + 8'd1;
		return {n, (n == 8'd0), 1'b0, (o[3:0] == 4'hF), cy};
	endfunction

	function automatic logic [11:0] dec8(input logic [7:0] o, input logic cy);
		logic [7:0] n;
		n = o - 8'd1;
		return {n, (n == 8'd0), 1'b1, (o[3:0] == 4'h0), cy};
	endfunction

	logic [15:0] bc, de, hl, addv, len;
	logic [16:0] sum;
	logic [12:0] sum_lo;
	logic [11:0] r8;

	assign bc = {cur.b, cur.c};
	assign de = {cur.d, cur.e};
	assign hl = {cur.h, cur.l};
	assign addv = op[4] ? de : bc;
	assign sum = {1'b0, hl} + {1'b0, addv};
	assign sum_lo = {1'b0, hl[11:0]} + {1'b0, addv[11:0]};

	always_comb begin
		nxt = cur;
		ctl = '0;
		ctl.cyc = 3'd1;
		len = 16'd1;
		r8 = '0;
		unique case (op)
			OP_NOP: ;
			OP_LD_BC_D16: begin {nxt.b, nxt.c} = imm; len = 16'd3; ctl.cyc = 3'd3; end
			OP_LD_MBC_A: begin
				ctl.mem_we = 1'b1; ctl.waddr = bc; ctl.wdata = cur.a; ctl.cyc = 3'd2;
			end
			OP_INC_BC: begin {nxt.b, nxt.c} = bc + 16'd1; ctl.cyc = 3'd2; end
			OP_INC_B: begin r8 = inc8(cur.b, cur.f[0]); {nxt.b, nxt.f} = r8; end
			OP_DEC_B: begin r8 = dec8(cur.b, cur.f[0]); {nxt.b, nxt.f} = r8; end
			OP_LD_B_D8: begin nxt.b = imm[7:0]; len = 16'd2; ctl.cyc = 3'd2; end
			OP_RLCA: begin nxt.a = {cur.a[6:0], cur.a[7]}; nxt.f = {3'b000, cur.a[7]}; end
			OP_LD_MA16_SP: begin
				ctl.mem_we = 1'b1; ctl.waddr = imm; ctl.wdata = sp[7:0];
				ctl.sp_hi = 1'b1; ctl.hi_addr = imm + 16'd1;
				len = 16'd3; ctl.cyc = 3'd5;
			end
			OP_ADD_HL_BC, OP_ADD_HL_DE: begin
				{nxt.h, nxt.l} = sum[15:0];
				nxt.f = {cur.f[3], 1'b0, sum_lo[12], sum[16]};
				ctl.cyc = 3'd2;
			end
			OP_LD_A_MBC: begin ctl.mem_re = 1'b1; ctl.raddr = bc; ctl.cyc = 3'd2; end
			OP_DEC_BC: begin {nxt.b, nxt.c} = bc - 16'd1; ctl.cyc = 3'd2; end
			OP_INC_C: begin r8 = inc8(cur.c, cur.f[0]); {nxt.c, nxt.f} = r8; end
			OP_DEC_C: begin r8 = dec8(cur.c, cur.f[0]); {nxt.c, nxt.f} = r8; end
			OP_LD_C_D8: begin nxt.c = imm[7:0]; len = 16'd2; ctl.cyc = 3'd2; end
			OP_RRCA: begin nxt.a = {cur.a[0], cur.a[7:1]}; nxt.f = {3'b000, cur.a[0]}; end
			OP_STOP: len = 16'd2;
			OP_LD_DE_D16: begin {nxt.d, nxt.e} = imm; len = 16'd3; ctl.cyc = 3'd3; end
			OP_LD_MDE_A: begin
				ctl.mem_we = 1'b1; ctl.waddr = de; ctl.wdata = cur.a; ctl.cyc = 3'd2;
			end
			OP_INC_DE: begin {nxt.d, nxt.e} = de + 16'd1; ctl.cyc = 3'd2; end
			OP_INC_D: begin r8 = inc8(cur.d, cur.f[0]); {nxt.d, nxt.f} = r8; end
			OP_DEC_D: begin r8 = dec8(cur.d, cur.f[0]); {nxt.d, nxt.f} = r8; end
			OP_LD_D_D8: begin nxt.d = imm[7:0]; len = 16'd2; ctl.cyc = 3'd2; end
			OP_RLA: begin nxt.a = {cur.a[6:0], cur.f[0]}; nxt.f = {3'b000, cur.a[7]}; end
			OP_JR: begin len = 16'd2 + {{8{imm[7]}}, imm[7:0]}; ctl.cyc = 3'd3; end
			OP_LD_A_MDE: begin ctl.mem_re = 1'b1; ctl.raddr = de; ctl.cyc = 3'd2; end
			OP_DEC_DE: begin {nxt.d, nxt.e} = de - 16'd1; ctl.cyc = 3'd2; end
			OP_INC_E: begin r8 = inc8(cur.e, cur.f[0]); {nxt.e, nxt.f} = r8; end
			OP_DEC_E: begin r8 = dec8(cur.e, cur.f[0]); {nxt.e, nxt.f} = r8; end
			OP_LD_E_D8: begin nxt.e = imm[7:0]; len = 16'd2; ctl.cyc = 3'd2; end
			OP_RRA: begin nxt.a = {cur.f[0], cur.a[7:1]}; nxt.f = {3'b000, cur.a[0]}; end
			default: ;
		endcase
		nxt.pc = cur.pc + len;
	end

endmodule
